/* rtl/core/bpcr_pkg.sv */
`default_nettype none

package bpcr_pkg;

  localparam int VW        = 32;  // velocity and position width
  localparam int DIFW      = 33;  // difference of two 32-bit values
  localparam int PRODW     = 66;  // product of two differences
  localparam int DOTW      = 67;  // dot product
  localparam int MAGW      = 66;  // magnitude of the dot product
  localparam int DENW      = 66;  // squared separation
  localparam int HALFW     = 33;  // split point of the numerator product
  localparam int NUMW      = 99;  // |dot| * |dp component|
  localparam int QW        = 34;  // quotient bits, one divider stage each
  localparam int DELW      = 35;  // signed exchanged component
  localparam int DW        = 37;  // signed velocity difference after exchange
  localparam int GW        = 16;  // gain width
  localparam int MW        = 54;  // difference times gain
  localparam int XW        = 56;  // damping accumulator
  localparam int GAIN_FRAC = 15;

  localparam logic [GW-1:0] GAIN_RESET = 16'd28508;

  typedef struct packed {
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
    logic signed [VW-1:0] v2x;
    logic signed [VW-1:0] v2y;
    logic                 collided;
    logic                 coincident;
    logic                 negx;
    logic                 negy;
  } side_t;

  typedef struct packed {
    logic [VW-1:0] v1x;
    logic [VW-1:0] v1y;
    logic [VW-1:0] v2x;
    logic [VW-1:0] v2y;
    logic          collided;
    logic          coincident;
  } res_t;

  typedef struct packed {
    logic [NUMW-1:0] rem;
    logic            qb;
  } step_t;

  // One restoring division step against the divisor shifted up by sh.
  function automatic step_t div_step(input logic [NUMW-1:0] rem,
                                     input logic [DENW-1:0] den, input int sh);
    logic [NUMW-1:0] dsh;
    step_t           r;
    dsh = NUMW'(den) << sh;
    if (rem >= dsh) begin
      r.rem = rem - dsh;
      r.qb  = 1'b1;
    end else begin
      r.rem = rem;
      r.qb  = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ball_pair_collision_response.sv */
// Equal-mass 2D elastic collision response for one ball pair per transfer.
// An input transfer carries both balls' positions and velocities in signed
// Q16.16; the matching output transfer carries the new velocities,
// saturated to 32 bits, plus two flags. When the balls approach (the dot
// product of relative velocity and separation is negative) the velocity
// component along the line of centres is exchanged, rounded to nearest with
// halves away from zero, and both velocities are pulled toward their mean by
// the restitution gain (unsigned Q1.15, reset 0.87, rounded half up). When
// the separation is zero the velocities pass through and coincident is set;
// when the balls do not approach they pass through with both flags clear.
// The block is fully pipelined and accepts one pair every cycle while the
// output is not stalled; each pair passes through 6 stages of
// differences and products, 34 restoring divider stages (one quotient bit
// each) plus a rounding stage, and 4 damping stages. The whole pipeline
// advances together and holds while a result waits on the output, so a
// stall loses or repeats nothing. The gain register should be written only
// while no pair is in flight.

`default_nettype none

module ball_pair_collision_response
  import bpcr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,

  // Fields from bit 0 up: first_pos_x, first_pos_y, second_pos_x,
  // second_pos_y, first_vel_x, first_vel_y, second_vel_x, second_vel_y.
  input  wire logic [255:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,

  // Fields from bit 0 up: new_first_vel_x, new_first_vel_y,
  // new_second_vel_x, new_second_vel_y.
  output logic [127:0]      out_tdata,
  // Fields from bit 0 up: collided, coincident.
  output logic [1:0]        out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,

  // Restitution gain write channel.
  input  wire logic [15:0]  cfg_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready
);

  logic [GW-1:0] gain_r;
  logic          en;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  logic            f_vld;
  side_t           f_side;
  logic [NUMW-1:0] f_numx, f_numy;
  logic [DENW-1:0] f_den;

  bpcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid && in_tready),
    .p1x      (in_tdata[31:0]),
    .p1y      (in_tdata[63:32]),
    .p2x      (in_tdata[95:64]),
    .p2y      (in_tdata[127:96]),
    .v1x      (in_tdata[159:128]),
    .v1y      (in_tdata[191:160]),
    .v2x      (in_tdata[223:192]),
    .v2y      (in_tdata[255:224]),
    .out_vld  (f_vld),
    .out_side (f_side),
    .out_numx (f_numx),
    .out_numy (f_numy),
    .out_den  (f_den)
  );

  logic          d_vld;
  side_t         d_side;
  logic [QW-1:0] d_qx, d_qy;

  // Quotients are only used when the pair approaches, which implies a
  // nonzero divisor; otherwise they are don't-care.
  bpcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_side  (f_side),
    .in_numx  (f_numx),
    .in_numy  (f_numy),
    .in_den   (f_den),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_qx   (d_qx),
    .out_qy   (d_qy)
  );

  res_t res;

  bpcr_damp u_damp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld),
    .in_side  (d_side),
    .in_qx    (d_qx),
    .in_qy    (d_qy),
    .gain     (gain_r),
    .out_vld  (out_tvalid),
    .out_res  (res)
  );

  assign out_tdata = {res.v2y, res.v2x, res.v1y, res.v1x};
  assign out_tuser = {res.coincident, res.collided};

  // A coincident pair can never be treated as approaching.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("collided and coincident both set");

  // A waiting result freezes the whole pipeline, input side included.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");

  // After reset the pipeline is empty.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

/* rtl/core/bpcr_front.sv */
`default_nettype none

module bpcr_front
  import bpcr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic [VW-1:0]         p1x,
  input  wire logic [VW-1:0]         p1y,
  input  wire logic [VW-1:0]         p2x,
  input  wire logic [VW-1:0]         p2y,
  input  wire logic [VW-1:0]         v1x,
  input  wire logic [VW-1:0]         v1y,
  input  wire logic [VW-1:0]         v2x,
  input  wire logic [VW-1:0]         v2y,
  output logic                       out_vld,
  output side_t                      out_side,
  output logic [NUMW-1:0]            out_numx,
  output logic [NUMW-1:0]            out_numy,
  output logic [DENW-1:0]            out_den
);

  logic [6:1] vld_r;
  side_t      s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;

  logic signed [DIFW-1:0]  dpx_r, dpy_r, dvx_r, dvy_r;
  logic signed [PRODW-1:0] px_r, py_r, sqx_r, sqy_r;
  logic [DIFW-1:0]         adx2_r, ady2_r, adx3_r, ady3_r, adx4_r, ady4_r;
  logic signed [DOTW-1:0]  dot_r;
  logic [DENW-1:0]         den3_r, den4_r, den5_r, den6_r;
  logic [MAGW-1:0]         mag_r;
  logic [PRODW-1:0]        plx_r, phx_r, ply_r, phy_r;
  logic [NUMW-1:0]         numx_r, numy_r;

  side_t s1_nxt;
  always_comb begin
    s1_nxt            = '0;
    s1_nxt.v1x        = signed'(v1x);
    s1_nxt.v1y        = signed'(v1y);
    s1_nxt.v2x        = signed'(v2x);
    s1_nxt.v2y        = signed'(v2y);
  end

  // Flags picked up along the way travel with the velocities.
  side_t s2_nxt, s4_nxt;
  always_comb begin
    s2_nxt            = s1_r;
    s2_nxt.coincident = (dpx_r == '0) && (dpy_r == '0);
    s2_nxt.negx       = dpx_r[DIFW-1];
    s2_nxt.negy       = dpy_r[DIFW-1];
    s4_nxt            = s3_r;
    s4_nxt.collided   = dot_r[DOTW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: differences.
      s1_r  <= s1_nxt;
      dpx_r <= $signed({p2x[VW-1], p2x}) - $signed({p1x[VW-1], p1x});
      dpy_r <= $signed({p2y[VW-1], p2y}) - $signed({p1y[VW-1], p1y});
      dvx_r <= $signed({v2x[VW-1], v2x}) - $signed({v1x[VW-1], v1x});
      dvy_r <= $signed({v2y[VW-1], v2y}) - $signed({v1y[VW-1], v1y});

      // Stage 2: products and magnitudes of the separation.
      s2_r   <= s2_nxt;
      px_r   <= dvx_r * dpx_r;
      py_r   <= dvy_r * dpy_r;
      sqx_r  <= dpx_r * dpx_r;
      sqy_r  <= dpy_r * dpy_r;
      adx2_r <= dpx_r[DIFW-1] ? DIFW'(-dpx_r) : DIFW'(dpx_r);
      ady2_r <= dpy_r[DIFW-1] ? DIFW'(-dpy_r) : DIFW'(dpy_r);

      // Stage 3: dot product and squared separation.
      s3_r   <= s2_r;
      dot_r  <= DOTW'(px_r) + DOTW'(py_r);
      den3_r <= DENW'(unsigned'(sqx_r)) + DENW'(unsigned'(sqy_r));
      adx3_r <= adx2_r;
      ady3_r <= ady2_r;

      // Stage 4: approach test and magnitude of the dot product.
      s4_r   <= s4_nxt;
      mag_r  <= dot_r[DOTW-1] ? MAGW'(-dot_r) : MAGW'(dot_r);
      den4_r <= den3_r;
      adx4_r <= adx3_r;
      ady4_r <= ady3_r;

      // Stage 5: numerator partial products, 33 by 33 bits each.
      s5_r   <= s4_r;
      plx_r  <= mag_r[HALFW-1:0] * adx4_r;
      phx_r  <= mag_r[MAGW-1:HALFW] * adx4_r;
      ply_r  <= mag_r[HALFW-1:0] * ady4_r;
      phy_r  <= mag_r[MAGW-1:HALFW] * ady4_r;
      den5_r <= den4_r;

      // Stage 6: numerator sums.
      s6_r   <= s5_r;
      numx_r <= (NUMW'(phx_r) << HALFW) + NUMW'(plx_r);
      numy_r <= (NUMW'(phy_r) << HALFW) + NUMW'(ply_r);
      den6_r <= den5_r;
    end
  end

  assign out_vld  = vld_r[6];
  assign out_side = s6_r;
  assign out_numx = numx_r;
  assign out_numy = numy_r;
  assign out_den  = den6_r;

endmodule

`default_nettype wire

/* rtl/core/bpcr_div.sv */
`default_nettype none

module bpcr_div
  import bpcr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire side_t           in_side,
  input  wire logic [NUMW-1:0] in_numx,
  input  wire logic [NUMW-1:0] in_numy,
  input  wire logic [DENW-1:0] in_den,
  output logic                 out_vld,
  output side_t                out_side,
  output logic [QW-1:0]        out_qx,
  output logic [QW-1:0]        out_qy
);

  // One quotient bit per stage, most significant first, then a rounding stage.
  logic [QW-1:0]   vld_r;
  side_t           side_r [QW];
  logic [DENW-1:0] den_r  [QW];
  logic [NUMW-1:0] remx_r [QW];
  logic [NUMW-1:0] remy_r [QW];
  logic [QW-1:0]   qx_r   [QW];
  logic [QW-1:0]   qy_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            v_src;
    side_t           s_src;
    logic [DENW-1:0] d_src;
    logic [NUMW-1:0] rx_src, ry_src;
    logic [QW-1:0]   qx_src, qy_src;
    logic [QW-1:0]   qx_nxt, qy_nxt;
    step_t           stx, sty;

    if (k == 0) begin : g_first
      assign v_src  = in_vld;
      assign s_src  = in_side;
      assign d_src  = in_den;
      assign rx_src = in_numx;
      assign ry_src = in_numy;
      assign qx_src = '0;
      assign qy_src = '0;
    end else begin : g_next
      assign v_src  = vld_r[k-1];
      assign s_src  = side_r[k-1];
      assign d_src  = den_r[k-1];
      assign rx_src = remx_r[k-1];
      assign ry_src = remy_r[k-1];
      assign qx_src = qx_r[k-1];
      assign qy_src = qy_r[k-1];
    end

    assign stx = div_step(rx_src, d_src, QW - 1 - k);
    assign sty = div_step(ry_src, d_src, QW - 1 - k);

    // Earlier stages only set higher bits, so this bit is still clear.
    assign qx_nxt = qx_src | (QW'(stx.qb) << (QW - 1 - k));
    assign qy_nxt = qy_src | (QW'(sty.qb) << (QW - 1 - k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_src;
        den_r[k]  <= d_src;
        remx_r[k] <= stx.rem;
        remy_r[k] <= sty.rem;
        qx_r[k]   <= qx_nxt;
        qy_r[k]   <= qy_nxt;
      end
    end
  end

  // Round to nearest, halves away from zero (all values here are magnitudes).
  logic          rvld_r;
  side_t         rside_r;
  logic [QW-1:0] rqx_r, rqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (en) begin
      rvld_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rside_r <= side_r[QW-1];
      rqx_r   <= qx_r[QW-1] + QW'({remx_r[QW-1], 1'b0} >= (NUMW+1)'(den_r[QW-1]));
      rqy_r   <= qy_r[QW-1] + QW'({remy_r[QW-1], 1'b0} >= (NUMW+1)'(den_r[QW-1]));
    end
  end

  assign out_vld  = rvld_r;
  assign out_side = rside_r;
  assign out_qx   = rqx_r;
  assign out_qy   = rqy_r;

endmodule

`default_nettype wire

/* rtl/core/bpcr_damp.sv */
`default_nettype none

module bpcr_damp
  import bpcr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire side_t         in_side,
  input  wire logic [QW-1:0] in_qx,
  input  wire logic [QW-1:0] in_qy,
  input  wire logic [GW-1:0] gain,
  output logic               out_vld,
  output res_t               out_res
);

  localparam int YW = XW - GAIN_FRAC - 1;

  logic [4:1] vld_r;
  side_t      s1_r, s2_r, s3_r;

  logic signed [DW-1:0]   d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [DIFW-1:0] sx_r, sy_r;
  logic signed [MW-1:0]   m1x_r, m1y_r, m2x_r, m2y_r;
  logic signed [XW-1:0]   ssx_r, ssy_r;
  logic signed [XW-1:0]   x1x_r, x1y_r, x2x_r, x2y_r;
  res_t                   res_r;

  // Twice the exchanged component, signed opposite to the separation.
  logic signed [DW-1:0] del2x, del2y;
  always_comb begin
    del2x = $signed({3'b000, in_qx}) <<< 1;
    del2y = $signed({3'b000, in_qy}) <<< 1;
    if (!in_side.negx) del2x = -del2x;
    if (!in_side.negy) del2y = -del2y;
  end

  function automatic logic [VW-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [YW-1:0] y;
    y = YW'(x >>> (GAIN_FRAC + 1));
    if (y > $signed(YW'(32'sh7fffffff))) return 32'h7fffffff;
    else if (y < -$signed(YW'(33'sh080000000))) return 32'h80000000;
    else return y[VW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: velocity differences after the exchange and velocity sums.
      s1_r  <= in_side;
      d1x_r <= DW'(in_side.v1x) - DW'(in_side.v2x) + del2x;
      d1y_r <= DW'(in_side.v1y) - DW'(in_side.v2y) + del2y;
      d2x_r <= DW'(in_side.v2x) - DW'(in_side.v1x) - del2x;
      d2y_r <= DW'(in_side.v2y) - DW'(in_side.v1y) - del2y;
      sx_r  <= DIFW'(in_side.v1x) + DIFW'(in_side.v2x);
      sy_r  <= DIFW'(in_side.v1y) + DIFW'(in_side.v2y);

      // Stage 2: gain products.
      s2_r  <= s1_r;
      m1x_r <= MW'(d1x_r * $signed({1'b0, gain}));
      m1y_r <= MW'(d1y_r * $signed({1'b0, gain}));
      m2x_r <= MW'(d2x_r * $signed({1'b0, gain}));
      m2y_r <= MW'(d2y_r * $signed({1'b0, gain}));
      ssx_r <= XW'(sx_r) <<< GAIN_FRAC;
      ssy_r <= XW'(sy_r) <<< GAIN_FRAC;

      // Stage 3: mean term plus damped difference plus rounding half.
      s3_r  <= s2_r;
      x1x_r <= ssx_r + XW'(m1x_r) + XW'(1 <<< GAIN_FRAC);
      x1y_r <= ssy_r + XW'(m1y_r) + XW'(1 <<< GAIN_FRAC);
      x2x_r <= ssx_r + XW'(m2x_r) + XW'(1 <<< GAIN_FRAC);
      x2y_r <= ssy_r + XW'(m2y_r) + XW'(1 <<< GAIN_FRAC);

      // Stage 4: floor shift, saturation and pass-through select.
      res_r.collided   <= s3_r.collided;
      res_r.coincident <= s3_r.coincident;
      if (s3_r.collided) begin
        res_r.v1x <= sat(x1x_r);
        res_r.v1y <= sat(x1y_r);
        res_r.v2x <= sat(x2x_r);
        res_r.v2y <= sat(x2y_r);
      end else begin
        res_r.v1x <= s3_r.v1x;
        res_r.v1y <= s3_r.v1y;
        res_r.v2x <= s3_r.v2x;
        res_r.v2y <= s3_r.v2y;
      end
    end
  end

  assign out_vld = vld_r[4];
  assign out_res = res_r;

endmodule

`default_nettype wire
